@@ sv/sdag_pkg.sv @@
// Shared types and constants of the 2D strided address generator.
package sdag_pkg;

  localparam int unsigned MaxLanes     = 4;
  localparam int unsigned LanesDefault = 4;
  localparam int unsigned QueueDepth   = 2;
  localparam int unsigned AddrW        = 64;
  localparam int unsigned PosW         = 32;
  localparam int unsigned CfgIdxW      = 3;
  localparam int unsigned LaneW        = $clog2(MaxLanes);

  typedef enum logic [CfgIdxW-1:0] {
    CFG_SRC_BASE  = 3'd0,
    CFG_DST_BASE  = 3'd1,
    CFG_ELEM_SIZE = 3'd2,
    CFG_ROWS      = 3'd3,
    CFG_COLS      = 3'd4,
    CFG_SRC_PITCH = 3'd5,
    CFG_DST_PITCH = 3'd6
  } cfg_idx_e;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_ISSUE,
    BK_DRAIN,
    BK_HAND
  } back_state_e;

  typedef struct packed {
    logic [AddrW-1:0] src_base;
    logic [AddrW-1:0] dst_base;
    logic [PosW-1:0]  elem_bytes;
    logic [PosW-1:0]  rows;
    logic [PosW-1:0]  cols;
    logic [PosW-1:0]  src_pitch;
    logic [PosW-1:0]  dst_pitch;
  } cfg_t;

  // One beat as classified by the front: grid position of each lane.
  typedef struct packed {
    logic [MaxLanes-1:0][PosW-1:0] row;
    logic [MaxLanes-1:0][PosW-1:0] col;
    logic [MaxLanes-1:0]           mask;
    logic                          last;
  } entry_t;

  typedef struct packed {
    logic [MaxLanes-1:0][AddrW-1:0] src;
    logic [MaxLanes-1:0][AddrW-1:0] dst;
    logic [MaxLanes-1:0]            mask;
    logic                           last;
  } result_t;

endpackage

@@ sv/sdag_front.sv @@
// Front end: holds the grid position and splits each tick into lane positions.
module sdag_front #(
  parameter int unsigned LANES = sdag_pkg::LanesDefault
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             accept_i,
  input  logic             restart_i,
  input  sdag_pkg::cfg_t   cfg_i,
  output logic             has_work_o,
  output sdag_pkg::entry_t entry_o
);
  import sdag_pkg::*;

  logic [PosW-1:0] cur_row_q, cur_row_d;
  logic [PosW-1:0] cur_col_q, cur_col_d;

  always_comb begin
    logic [PosW-1:0] row;
    logic [PosW-1:0] col;
    logic [PosW-1:0] col_inc;
    row     = restart_i ? '0 : cur_row_q;
    col     = restart_i ? '0 : cur_col_q;
    col_inc = '0;
    has_work_o = (row < cfg_i.rows);
    entry_o    = '0;
    for (int l = 0; l < LANES; l++) begin
      if (row < cfg_i.rows) begin
        entry_o.row[l]  = row;
        entry_o.col[l]  = col;
        entry_o.mask[l] = 1'b1;
        col_inc = col + 1'b1;
        // wrap to the next row once the column count is reached
        if (col_inc >= cfg_i.cols) begin
          col = '0;
          row = row + 1'b1;
        end else begin
          col = col_inc;
        end
      end
    end
    entry_o.last = (row >= cfg_i.rows);
    cur_row_d    = row;
    cur_col_d    = col;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_row_q <= '0;
      cur_col_q <= '0;
    end else if (accept_i) begin
      cur_row_q <= cur_row_d;
      cur_col_q <= cur_col_d;
    end
  end

endmodule

@@ sv/sdag_queue.sv @@
// Short queue of classified beats between front and back.
module sdag_queue #(
  parameter int unsigned Depth = sdag_pkg::QueueDepth
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  sdag_pkg::entry_t data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             empty_o,
  output sdag_pkg::entry_t data_o
);
  import sdag_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  entry_t            mem_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]   count_q;
  logic              do_push, do_pop;

  assign full_o  = (count_q == CntW'(Depth));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

@@ sv/sdag_back.sv @@
// Back end: walks the lanes of one beat through the address multipliers.
module sdag_back #(
  parameter int unsigned LANES = sdag_pkg::LanesDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  sdag_pkg::cfg_t    cfg_i,
  input  logic              q_empty_i,
  input  sdag_pkg::entry_t  q_data_i,
  output logic              q_pop_o,
  input  logic              out_free_i,
  output logic              out_load_o,
  output sdag_pkg::result_t result_o
);
  import sdag_pkg::*;

  back_state_e state_q, state_d;
  entry_t      work_q;
  logic [LaneW-1:0] lane_q;
  logic        issue;
  logic        last_issue;

  // stage 1: row times pitch
  logic             s1_vld_q, s1_end_q;
  logic [LaneW-1:0] s1_lane_q;
  logic [PosW-1:0]  s1_ps_q, s1_pd_q, s1_col_q;
  // stage 2: element index
  logic             s2_vld_q, s2_end_q;
  logic [LaneW-1:0] s2_lane_q;
  logic [PosW-1:0]  s2_is_q, s2_id_q;
  // stage 3: byte offset
  logic             s3_vld_q, s3_end_q;
  logic [LaneW-1:0] s3_lane_q;
  logic [AddrW-1:0] s3_os_q, s3_od_q;

  logic [MaxLanes-1:0][AddrW-1:0] build_src_q, build_dst_q;

  assign last_issue = (lane_q == LaneW'(LANES - 1));

  always_comb begin
    state_d = state_q;
    case (state_q)
      BK_IDLE:  if (!q_empty_i) state_d = BK_ISSUE;
      BK_ISSUE: if (last_issue) state_d = BK_DRAIN;
      BK_DRAIN: if (s3_vld_q && s3_end_q) state_d = BK_HAND;
      BK_HAND:  if (out_free_i) state_d = BK_IDLE;
      default:  state_d = BK_IDLE;
    endcase
  end

  always_comb begin
    q_pop_o    = 1'b0;
    issue      = 1'b0;
    out_load_o = 1'b0;
    case (state_q)
      BK_IDLE:  q_pop_o    = !q_empty_i;
      BK_ISSUE: issue      = 1'b1;
      BK_HAND:  out_load_o = out_free_i;
      default:  ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= BK_IDLE;
      lane_q   <= '0;
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      s3_vld_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      if (q_pop_o) begin
        lane_q <= '0;
      end else if (issue) begin
        lane_q <= lane_q + 1'b1;
      end
      s1_vld_q <= issue;
      s2_vld_q <= s1_vld_q;
      s3_vld_q <= s2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      work_q <= q_data_i;
    end
    s1_lane_q <= lane_q;
    s1_end_q  <= last_issue;
    s1_ps_q   <= work_q.row[lane_q] * cfg_i.src_pitch;
    s1_pd_q   <= work_q.row[lane_q] * cfg_i.dst_pitch;
    s1_col_q  <= work_q.col[lane_q];
    s2_lane_q <= s1_lane_q;
    s2_end_q  <= s1_end_q;
    s2_is_q   <= s1_ps_q + s1_col_q;
    s2_id_q   <= s1_pd_q + s1_col_q;
    s3_lane_q <= s2_lane_q;
    s3_end_q  <= s2_end_q;
    s3_os_q   <= {{(AddrW-PosW){1'b0}}, s2_is_q} * {{(AddrW-PosW){1'b0}}, cfg_i.elem_bytes};
    s3_od_q   <= {{(AddrW-PosW){1'b0}}, s2_id_q} * {{(AddrW-PosW){1'b0}}, cfg_i.elem_bytes};
    if (s3_vld_q) begin
      build_src_q[s3_lane_q] <= cfg_i.src_base + s3_os_q;
      build_dst_q[s3_lane_q] <= cfg_i.dst_base + s3_od_q;
    end
  end

  // zero the addresses of lanes that carry nothing
  always_comb begin
    result_o      = '0;
    result_o.mask = work_q.mask;
    result_o.last = work_q.last;
    for (int l = 0; l < MaxLanes; l++) begin
      result_o.src[l] = work_q.mask[l] ? build_src_q[l] : '0;
      result_o.dst[l] = work_q.mask[l] ? build_dst_q[l] : '0;
    end
  end

endmodule

@@ sv/strided_2d_dma_address_gen_unit.sv @@
// Top level of the 2D strided DMA address generator.
// Each accepted tick that still has rows left yields one beat; the back end pops a beat,
// issues its LANES lanes into a 3-stage multiply/add pipeline, waits for the last lane
// to drain, then loads the beat into the output register once that is free, so a new
// beat is popped only after the previous one has been handed off.
// Reset clears the descriptor registers, the grid position and the queue.
module strided_2d_dma_address_gen_unit #(
  parameter int unsigned LANES = sdag_pkg::LanesDefault
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              push,
  output logic                              full,
  input  logic                              restart_i,
  output logic                              empty,
  input  logic                              pop,
  output logic [sdag_pkg::AddrW-1:0]        src_lane0_o,
  output logic [sdag_pkg::AddrW-1:0]        src_lane1_o,
  output logic [sdag_pkg::AddrW-1:0]        src_lane2_o,
  output logic [sdag_pkg::AddrW-1:0]        src_lane3_o,
  output logic [sdag_pkg::AddrW-1:0]        dst_lane0_o,
  output logic [sdag_pkg::AddrW-1:0]        dst_lane1_o,
  output logic [sdag_pkg::AddrW-1:0]        dst_lane2_o,
  output logic [sdag_pkg::AddrW-1:0]        dst_lane3_o,
  output logic [sdag_pkg::MaxLanes-1:0]     lane_mask_o,
  output logic                              transfer_last_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [sdag_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  logic [sdag_pkg::AddrW-1:0]        cfg_data_i
);
  import sdag_pkg::*;

  cfg_t    cfg_q;
  entry_t  front_entry, q_data;
  logic    accept, has_work, q_full, q_empty, q_pop;
  logic    out_valid_q, out_free, out_load;
  result_t back_result, out_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_SRC_BASE:  cfg_q.src_base   <= cfg_data_i;
        CFG_DST_BASE:  cfg_q.dst_base   <= cfg_data_i;
        CFG_ELEM_SIZE: cfg_q.elem_bytes <= cfg_data_i[PosW-1:0];
        CFG_ROWS:      cfg_q.rows       <= cfg_data_i[PosW-1:0];
        CFG_COLS:      cfg_q.cols       <= cfg_data_i[PosW-1:0];
        CFG_SRC_PITCH: cfg_q.src_pitch  <= cfg_data_i[PosW-1:0];
        CFG_DST_PITCH: cfg_q.dst_pitch  <= cfg_data_i[PosW-1:0];
        default:       ;
      endcase
    end
  end

  assign full   = q_full;
  assign accept = push && !q_full;

  sdag_front #(.LANES(LANES)) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .restart_i  (restart_i),
    .cfg_i      (cfg_q),
    .has_work_o (has_work),
    .entry_o    (front_entry)
  );

  // finished ticks leave nothing in the queue
  sdag_queue #(.Depth(QueueDepth)) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (accept && has_work),
    .data_i  (front_entry),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .data_o  (q_data)
  );

  sdag_back #(.LANES(LANES)) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .q_empty_i  (q_empty),
    .q_data_i   (q_data),
    .q_pop_o    (q_pop),
    .out_free_i (out_free),
    .out_load_o (out_load),
    .result_o   (back_result)
  );

  assign out_free = !out_valid_q || pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (pop) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q <= back_result;
    end
  end

  assign empty           = !out_valid_q;
  assign src_lane0_o     = out_q.src[0];
  assign src_lane1_o     = out_q.src[1];
  assign src_lane2_o     = out_q.src[2];
  assign src_lane3_o     = out_q.src[3];
  assign dst_lane0_o     = out_q.dst[0];
  assign dst_lane1_o     = out_q.dst[1];
  assign dst_lane2_o     = out_q.dst[2];
  assign dst_lane3_o     = out_q.dst[3];
  assign lane_mask_o     = out_q.mask;
  assign transfer_last_o = out_q.last;

endmodule

@@ sim/tb.sv @@
// Testbench for the 2D strided DMA address generator: predicts every beat and checks it.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sdag_pkg::*;

  localparam int unsigned Lanes          = LanesDefault;
  localparam int unsigned Latency        = Lanes + 6;
  localparam int unsigned SettleCycles   = 4 * Latency;
  localparam int unsigned WatchdogLimit  = 3000;
  localparam int unsigned HoldOffCycles  = 300;
  localparam int unsigned MaxReports     = 200;
  localparam int          TicksPerPhase  = 185;
  localparam int          MaxTicksPerRun = 12;
  localparam logic [CfgIdxW-1:0] CfgUnused = 3'd7;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                push = 1'b0;
  logic                full;
  logic                restart_i = 1'b0;
  logic                empty;
  logic                pop = 1'b0;
  logic [AddrW-1:0]    src_lane0_o, src_lane1_o, src_lane2_o, src_lane3_o;
  logic [AddrW-1:0]    dst_lane0_o, dst_lane1_o, dst_lane2_o, dst_lane3_o;
  logic [MaxLanes-1:0] lane_mask_o;
  logic                transfer_last_o;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [AddrW-1:0]    cfg_data_i = '0;

  // Shadow of the descriptor registers and the grid walk position.
  cfg_t                shadow_desc = '0;
  logic [PosW-1:0]     walk_row = '0;
  logic [PosW-1:0]     walk_col = '0;
  result_t             pending_beats[$];

  int                  n_errors = 0;
  int                  ticks_sent = 0;
  int                  send_idle_pct = 0;
  int                  recv_stall_pct = 0;
  int                  recv_hold = 0;
  int                  quiet_cycles = 0;

  strided_2d_dma_address_gen_unit #(
    .LANES(Lanes)
  ) u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push           (push),
    .full           (full),
    .restart_i      (restart_i),
    .empty          (empty),
    .pop            (pop),
    .src_lane0_o    (src_lane0_o),
    .src_lane1_o    (src_lane1_o),
    .src_lane2_o    (src_lane2_o),
    .src_lane3_o    (src_lane3_o),
    .dst_lane0_o    (dst_lane0_o),
    .dst_lane1_o    (dst_lane1_o),
    .dst_lane2_o    (dst_lane2_o),
    .dst_lane3_o    (dst_lane3_o),
    .lane_mask_o    (lane_mask_o),
    .transfer_last_o(transfer_last_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Index math wraps at 32 bits, the address at 64 bits.
  function automatic logic [AddrW-1:0] grid_address(input logic [AddrW-1:0] base,
                                                    input logic [PosW-1:0] pitch,
                                                    input logic [PosW-1:0] row,
                                                    input logic [PosW-1:0] col);
    logic [PosW-1:0] idx;
    idx = row * pitch + col;
    return base + {32'd0, idx} * {32'd0, shadow_desc.elem_bytes};
  endfunction

  function automatic bit next_beat(input bit restart, output result_t beat);
    beat = '0;
    if (restart) begin
      walk_row = '0;
      walk_col = '0;
    end
    if (walk_row >= shadow_desc.rows) return 1'b0;
    for (int lane = 0; lane < Lanes; lane++) begin
      if (walk_row >= shadow_desc.rows) break;
      beat.src[lane]  = grid_address(shadow_desc.src_base, shadow_desc.src_pitch,
                                     walk_row, walk_col);
      beat.dst[lane]  = grid_address(shadow_desc.dst_base, shadow_desc.dst_pitch,
                                     walk_row, walk_col);
      beat.mask[lane] = 1'b1;
      walk_col = walk_col + 1;
      // A column at or past the count also wraps to the next row.
      if (walk_col >= shadow_desc.cols) begin
        walk_col = '0;
        walk_row = walk_row + 1;
      end
    end
    beat.last = (walk_row >= shadow_desc.rows);
    return 1'b1;
  endfunction

  function void flag_field(input string field, input logic [AddrW-1:0] want,
                           input logic [AddrW-1:0] got);
    n_errors++;
    if (n_errors <= MaxReports)
      $error("%s: expected %0h, got %0h", field, want, got);
  endfunction

  always @(posedge clk_i) begin : beat_checker
    result_t          want;
    logic [AddrW-1:0] got_src [MaxLanes];
    logic [AddrW-1:0] got_dst [MaxLanes];
    if (rst_ni && pop && !empty) begin
      got_src = '{src_lane0_o, src_lane1_o, src_lane2_o, src_lane3_o};
      got_dst = '{dst_lane0_o, dst_lane1_o, dst_lane2_o, dst_lane3_o};
      if (pending_beats.size() == 0) begin
        n_errors++;
        if (n_errors <= MaxReports) $error("beat popped with none pending");
      end else begin
        want = pending_beats.pop_front();
        for (int i = 0; i < MaxLanes; i++) begin
          if (got_src[i] !== want.src[i])
            flag_field($sformatf("src_lane%0d", i), want.src[i], got_src[i]);
          if (got_dst[i] !== want.dst[i])
            flag_field($sformatf("dst_lane%0d", i), want.dst[i], got_dst[i]);
        end
        if (lane_mask_o !== want.mask)
          flag_field("lane_mask", AddrW'(want.mask), AddrW'(lane_mask_o));
        if (transfer_last_o !== want.last)
          flag_field("transfer_last", AddrW'(want.last), AddrW'(transfer_last_o));
      end
    end
    if (recv_hold > 0) begin
      pop <= 1'b0;
      recv_hold--;
    end else begin
      pop <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((push && !full) || (pop && !empty) || (cfg_valid_i && cfg_ready_o))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= WatchdogLimit) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  // Offer one tick; push stays high on return so back-to-back ticks need no gap.
  task automatic send_tick(input bit restart);
    int      idle;
    result_t beat;
    idle = 0;
    while ($urandom_range(99) < send_idle_pct) idle++;
    if (idle != 0) begin
      push <= 1'b0;
      repeat (idle) @(posedge clk_i);
    end
    push      <= 1'b1;
    restart_i <= restart;
    do @(posedge clk_i); while (full);
    ticks_sent++;
    if (next_beat(restart, beat)) begin
      pending_beats.push_back(beat);
    end
  endtask

  // Hold the sender until every beat has come out and the pipeline is quiet.
  task automatic settle();
    push <= 1'b0;
    while (pending_beats.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic cfg_write(input logic [CfgIdxW-1:0] idx, input logic [AddrW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_SRC_BASE:  shadow_desc.src_base   = data;
      CFG_DST_BASE:  shadow_desc.dst_base   = data;
      CFG_ELEM_SIZE: shadow_desc.elem_bytes = data[PosW-1:0];
      CFG_ROWS:      shadow_desc.rows       = data[PosW-1:0];
      CFG_COLS:      shadow_desc.cols       = data[PosW-1:0];
      CFG_SRC_PITCH: shadow_desc.src_pitch  = data[PosW-1:0];
      CFG_DST_PITCH: shadow_desc.dst_pitch  = data[PosW-1:0];
      default: ;
    endcase
  endtask

  task automatic cfg_release();
    cfg_valid_i <= 1'b0;
  endtask

  // Upper bits of the 32-bit registers are random so that the block must drop them.
  task automatic load_desc(input cfg_t d, input bit poke_unused);
    cfg_write(CFG_SRC_BASE, d.src_base);
    cfg_write(CFG_DST_BASE, d.dst_base);
    cfg_write(CFG_ELEM_SIZE, {$urandom, d.elem_bytes});
    cfg_write(CFG_ROWS, {$urandom, d.rows});
    cfg_write(CFG_COLS, {$urandom, d.cols});
    cfg_write(CFG_SRC_PITCH, {$urandom, d.src_pitch});
    cfg_write(CFG_DST_PITCH, {$urandom, d.dst_pitch});
    if (poke_unused) cfg_write(CfgUnused, {$urandom, $urandom});
    cfg_release();
  endtask

  // All registers are zero after reset, so every tick finds the transfer done.
  task automatic test_idle_after_reset();
    send_tick(1'b0);
    send_tick(1'b1);
    send_tick(1'b0);
    settle();
  endtask

  task automatic test_address_extremes();
    cfg_t d;
    d            = '0;
    d.src_base   = 64'hFFFF_FFFF_FFFF_FFF0;
    d.dst_base   = '1;
    d.elem_bytes = '1;
    d.rows       = 32'd2;
    d.cols       = 32'd3;
    d.src_pitch  = '1;
    d.dst_pitch  = '0;
    load_desc(d, 1'b0);
    send_tick(1'b1);
    send_tick(1'b0);
    send_tick(1'b0);
    settle();
    d            = '0;
    d.elem_bytes = 32'd8;
    d.rows       = 32'd1;
    d.cols       = 32'd5;
    d.dst_pitch  = '1;
    load_desc(d, 1'b0);
    send_tick(1'b1);
    send_tick(1'b0);
    settle();
    d.src_base   = '1;
    d.rows       = '1;
    d.cols       = '1;
    d.src_pitch  = '1;
    d.elem_bytes = 32'h8000_0001;
    load_desc(d, 1'b0);
    send_tick(1'b1);
    send_tick(1'b0);
    settle();
  endtask

  // With no columns every element moves on to the next row.
  task automatic test_zero_columns();
    cfg_t d;
    d            = '0;
    d.src_base   = 64'h1000;
    d.dst_base   = 64'h8000_0000_0000_0000;
    d.elem_bytes = 32'd4;
    d.rows       = 32'd5;
    d.src_pitch  = 32'd16;
    d.dst_pitch  = 32'd3;
    load_desc(d, 1'b0);
    send_tick(1'b1);
    send_tick(1'b0);
    send_tick(1'b0);
    settle();
  endtask

  // Shrink the column count under a walk that is already past it.
  task automatic test_column_past_count();
    cfg_t d;
    d            = '0;
    d.src_base   = 64'h2000;
    d.dst_base   = 64'h3000;
    d.elem_bytes = 32'd2;
    d.rows       = 32'd3;
    d.cols       = 32'd10;
    d.src_pitch  = 32'd10;
    d.dst_pitch  = 32'd12;
    load_desc(d, 1'b0);
    send_tick(1'b1);
    settle();
    cfg_write(CFG_COLS, 64'd2);
    cfg_release();
    send_tick(1'b0);
    send_tick(1'b0);
    send_tick(1'b0);
    settle();
  endtask

  task automatic test_unused_index();
    cfg_write(CfgUnused, '1);
    cfg_write(CfgUnused, {$urandom, $urandom});
    cfg_release();
    send_tick(1'b1);
    send_tick(1'b0);
    settle();
  endtask

  // Stall the receiver long enough that the block backs up onto its input.
  task automatic test_backpressure();
    cfg_t d;
    d            = '0;
    d.src_base   = {$urandom, $urandom};
    d.dst_base   = {$urandom, $urandom};
    d.elem_bytes = 32'd4;
    d.rows       = 32'd16;
    d.cols       = 32'd16;
    d.src_pitch  = 32'd20;
    d.dst_pitch  = 32'd16;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    load_desc(d, 1'b0);
    recv_hold = HoldOffCycles;
    send_tick(1'b1);
    repeat (40) send_tick(1'b0);
    settle();
  endtask

  task automatic run_random_phase(input int send_pct, input int recv_pct);
    int   start;
    int   ticks;
    int   elems;
    cfg_t d;
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    start          = ticks_sent;
    while (ticks_sent - start < TicksPerPhase) begin
      d.src_base = {$urandom, $urandom};
      d.dst_base = {$urandom, $urandom};
      case ($urandom_range(3))
        0:       d.elem_bytes = $urandom;
        1:       d.elem_bytes = '0;
        default: d.elem_bytes = $urandom_range(1, 16);
      endcase
      case ($urandom_range(9))
        0:       d.rows = '0;
        1:       d.rows = $urandom;
        default: d.rows = $urandom_range(1, 6);
      endcase
      case ($urandom_range(9))
        0:       d.cols = '0;
        1:       d.cols = $urandom;
        default: d.cols = $urandom_range(1, 9);
      endcase
      d.src_pitch = ($urandom_range(3) == 0) ? $urandom : $urandom_range(0, 16);
      d.dst_pitch = ($urandom_range(3) == 0) ? $urandom : $urandom_range(0, 16);
      if (d.rows > 64 || d.cols > 64) begin
        ticks = MaxTicksPerRun;
      end else begin
        elems = d.rows * ((d.cols == 0) ? 1 : d.cols);
        ticks = (elems + Lanes - 1) / Lanes;
        if (ticks > MaxTicksPerRun) ticks = MaxTicksPerRun;
      end
      ticks = ticks + $urandom_range(0, 2);
      settle();
      load_desc(d, $urandom_range(3) == 0);
      // Mostly start clean; sometimes carry on from the old position or restart midway.
      send_tick($urandom_range(9) != 0);
      repeat (ticks) send_tick($urandom_range(19) == 0);
    end
    settle();
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_idle_after_reset();
    test_address_extremes();
    test_zero_columns();
    test_column_past_count();
    test_unused_index();
    test_backpressure();
    run_random_phase(0, 0);
    run_random_phase(60, 0);
    run_random_phase(0, 60);
    run_random_phase(29, 29);
    settle();
    if (n_errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

@@ sim.f @@
sv/sdag_pkg.sv
sv/sdag_front.sv
sv/sdag_queue.sv
sv/sdag_back.sv
sv/strided_2d_dma_address_gen_unit.sv
sim/tb.sv
